// ===== design/vdu_pkg.sv =====
// Shared types and constants of the vector distance unit.
// No dependencies; vdu_accum, vdu_alu and the top level import this package.
package vdu_pkg;

   localparam int MAX_LEN = 1024;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);

   localparam int SX_W  = 27;
   localparam int SXY_W = 42;
   localparam int SXX_W = 41;
   localparam int SDD_W = 43;
   localparam int SAD_W = 27;

   localparam int WIDE_W = 128;
   localparam int HALF_W = 64;
   localparam int Q_W    = 42;

   localparam logic [Q_W-1:0] RATIO_CAP = Q_W'(1) << 40;

   localparam logic [2:0] MODE_EUCLID     = 3'd0;
   localparam logic [2:0] MODE_COSINE     = 3'd1;
   localparam logic [2:0] MODE_PEARSON    = 3'd2;
   localparam logic [2:0] MODE_UNCENTRED  = 3'd3;
   localparam logic [2:0] MODE_SQ_PEARSON = 3'd4;
   localparam logic [2:0] MODE_MEAN_DOT   = 3'd5;
   localparam logic [2:0] MODE_COVAR      = 3'd6;
   localparam logic [2:0] MODE_MANHATTAN  = 3'd7;

   localparam logic REG_MODE = 1'b0;
   localparam logic REG_EPS  = 1'b1;

   typedef enum logic [2:0] {
      OP_MUL  = 3'd0,
      OP_SQRT = 3'd1,
      OP_DIV  = 3'd2,
      OP_DIV0 = 3'd3,
      OP_ADD  = 3'd4,
      OP_SUB  = 3'd5
   } alu_op_type;

   typedef enum logic [4:0] {
      SRC_ZERO, SRC_N, SRC_NM1, SRC_SX, SRC_SY, SRC_SXY, SRC_SXX, SRC_SYY,
      SRC_SDD16, SRC_SABD8, SRC_E, SRC_E16, SRC_MAGSXY, SRC_MAGRR,
      SRC_CX, SRC_CY, SRC_TMP, SRC_DEN
   } src_type;

   typedef enum logic [2:0] {
      DST_TMP, DST_DEN, DST_RR, DST_CX, DST_CY, DST_Q
   } dst_type;

   typedef struct packed {
      alu_op_type op;
      src_type    sa;
      src_type    sb;
      dst_type    dst;
      logic       last;
   } uop_type;

   typedef struct packed {
      logic              start;
      alu_op_type        op;
      logic [WIDE_W-1:0] a;
      logic [WIDE_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic [WIDE_W-1:0] result;
   } alu_rsp_type;

   typedef struct packed {
      logic        [CNT_W-1:0] count;
      logic signed [SX_W-1:0]  sx;
      logic signed [SX_W-1:0]  sy;
      logic signed [SXY_W-1:0] sxy;
      logic        [SXX_W-1:0] sxx;
      logic        [SXX_W-1:0] syy;
      logic        [SDD_W-1:0] sdd;
      logic        [SAD_W-1:0] sad;
   } sums_type;

endpackage

// ===== design/vdu_if.sv =====
// Handshake channels of the vector distance unit: element pairs in, distances out.
// Depends on nothing but the payload widths written here.
interface vdu_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] x_elem;
   logic signed [15:0] y_elem;
   logic               last_elem;

   modport source (output valid, x_elem, y_elem, last_elem, input ready);
   modport sink   (input valid, x_elem, y_elem, last_elem, output ready);
endinterface

interface vdu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] distance;

   modport source (output valid, distance, input ready);
   modport sink   (input valid, distance, output ready);
endinterface

// ===== design/vdu_accum.sv =====
// Running sums of the element pairs, built with one shared 17x17 multiplier.
// Depends on vdu_pkg.
module vdu_accum (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] x_elem,
   input  logic signed [15:0] y_elem,
   input  logic               last_elem,
   input  logic               clear,
   output logic               busy,
   output logic               vec_done,
   output vdu_pkg::sums_type  sums
);
   import vdu_pkg::*;

   typedef enum logic [4:0] {
      A_IDLE = 5'b00001,
      A_XY   = 5'b00010,
      A_XX   = 5'b00100,
      A_YY   = 5'b01000,
      A_DD   = 5'b10000
   } acc_state_type;

   acc_state_type      state_ff, state_in;
   logic signed [15:0] x_ff, y_ff;
   logic               last_ff, en_ff;
   sums_type           sums_ff, sums_in;

   logic signed [16:0] diff, ma, mb;
   logic signed [33:0] prod;
   logic        [16:0] abs_diff;

   assign diff     = 17'(x_ff) - 17'(y_ff);
   assign abs_diff = diff[16] ? 17'(-diff) : 17'(diff);

   always_comb begin
      unique case (state_ff)
         A_XY: begin
            ma = 17'(x_ff);
            mb = 17'(y_ff);
         end
         A_XX: begin
            ma = 17'(x_ff);
            mb = 17'(x_ff);
         end
         A_YY: begin
            ma = 17'(y_ff);
            mb = 17'(y_ff);
         end
         default: begin
            ma = diff;
            mb = diff;
         end
      endcase
   end

   assign prod = ma * mb;

   always_comb begin
      state_in = state_ff;
      sums_in  = sums_ff;
      unique case (state_ff)
         A_IDLE: if (start) state_in = A_XY;
         A_XY: begin
            state_in = A_XX;
            if (en_ff) begin
               sums_in.sxy   = sums_ff.sxy + SXY_W'(prod);
               sums_in.sx    = sums_ff.sx + SX_W'(x_ff);
               sums_in.sy    = sums_ff.sy + SX_W'(y_ff);
               sums_in.sad   = sums_ff.sad + SAD_W'(abs_diff);
               sums_in.count = sums_ff.count + CNT_W'(1);
            end
         end
         A_XX: begin
            state_in = A_YY;
            if (en_ff) sums_in.sxx = sums_ff.sxx + SXX_W'(prod);
         end
         A_YY: begin
            state_in = A_DD;
            if (en_ff) sums_in.syy = sums_ff.syy + SXX_W'(prod);
         end
         A_DD: begin
            state_in = A_IDLE;
            if (en_ff) sums_in.sdd = sums_ff.sdd + SDD_W'(prod);
         end
      endcase
      if (clear) sums_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         sums_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sums_ff  <= sums_in;
      end
      if (start && state_ff == A_IDLE) begin
         x_ff    <= x_elem;
         y_ff    <= y_elem;
         last_ff <= last_elem;
         // drop pairs beyond the maximum length
         en_ff   <= (sums_ff.count < CNT_W'(MAX_LEN));
      end
   end

   assign busy     = (state_ff != A_IDLE);
   assign vec_done = (state_ff == A_DD) && last_ff;
   assign sums     = sums_ff;

endmodule

// ===== design/vdu_alu.sv =====
// Shared iterative unit: shift-add multiply, digit square root, restoring divide, add/sub.
// Depends on vdu_pkg.
module vdu_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  vdu_pkg::alu_req_type req,
   output vdu_pkg::alu_rsp_type rsp
);
   import vdu_pkg::*;

   localparam int MUL_STEPS  = HALF_W;
   localparam int SQRT_STEPS = HALF_W;
   localparam int DIV_STEPS  = WIDE_W + 16;
   localparam int DIV0_STEPS = WIDE_W;

   typedef enum logic [3:0] {
      U_IDLE = 4'b0001,
      U_RUN  = 4'b0010,
      U_FIN  = 4'b0100,
      U_DONE = 4'b1000
   } alu_state_type;

   alu_state_type     state_ff, state_in;
   alu_op_type        op_ff, op_in;
   logic [WIDE_W-1:0] acc_ff, acc_in;
   logic [WIDE_W+1:0] aux_ff, aux_in;
   logic [WIDE_W-1:0] bq_ff, bq_in;
   logic [HALF_W-1:0] root_ff, root_in;
   logic [WIDE_W-1:0] res_ff, res_in;
   logic [7:0]        cnt_ff, cnt_in;
   logic              sat_ff, sat_in, dz_ff, dz_in, nz_ff, nz_in;

   logic [67:0]       rem_sq, trial;
   logic [WIDE_W+1:0] rem_dv, den_dv;
   logic [7:0]        last_cnt;
   logic [Q_W-1:0]    q_cur;

   assign rem_sq = {aux_ff[65:0], acc_ff[WIDE_W-1 -: 2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign rem_dv = {aux_ff[WIDE_W:0], acc_ff[WIDE_W-1]};
   assign den_dv = {2'b00, bq_ff};
   assign q_cur  = root_ff[Q_W-1:0];

   always_comb begin
      unique case (op_ff)
         OP_MUL:  last_cnt = 8'(MUL_STEPS - 1);
         OP_SQRT: last_cnt = 8'(SQRT_STEPS - 1);
         OP_DIV:  last_cnt = 8'(DIV_STEPS - 1);
         default: last_cnt = 8'(DIV0_STEPS - 1);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      acc_in   = acc_ff;
      aux_in   = aux_ff;
      bq_in    = bq_ff;
      root_in  = root_ff;
      res_in   = res_ff;
      cnt_in   = cnt_ff;
      sat_in   = sat_ff;
      dz_in    = dz_ff;
      nz_in    = nz_ff;
      unique case (state_ff)
         U_IDLE: if (req.start) begin
            op_in   = req.op;
            cnt_in  = '0;
            root_in = '0;
            sat_in  = 1'b0;
            dz_in   = (req.b == '0);
            nz_in   = (req.a == '0);
            state_in = U_RUN;
            unique case (req.op)
               OP_MUL: begin
                  acc_in = '0;
                  aux_in = {66'b0, req.a[HALF_W-1:0]};
                  bq_in  = {64'b0, req.b[HALF_W-1:0]};
               end
               OP_SQRT: begin
                  acc_in = req.a;
                  aux_in = '0;
               end
               OP_DIV, OP_DIV0: begin
                  acc_in = req.a;
                  aux_in = '0;
                  bq_in  = req.b;
               end
               OP_ADD: begin
                  res_in   = req.a + req.b;
                  state_in = U_DONE;
               end
               default: begin
                  res_in   = req.a - req.b;
                  state_in = U_DONE;
               end
            endcase
         end
         U_RUN: begin
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == last_cnt) state_in = U_FIN;
            unique case (op_ff)
               OP_MUL: begin
                  if (bq_ff[0]) acc_in = acc_ff + aux_ff[WIDE_W-1:0];
                  aux_in = {aux_ff[WIDE_W:0], 1'b0};
                  bq_in  = bq_ff >> 1;
               end
               OP_SQRT: begin
                  acc_in = {acc_ff[WIDE_W-3:0], 2'b00};
                  if (rem_sq >= trial) begin
                     aux_in  = {62'b0, rem_sq - trial};
                     root_in = {root_ff[HALF_W-2:0], 1'b1};
                  end else begin
                     aux_in  = {62'b0, rem_sq};
                     root_in = {root_ff[HALF_W-2:0], 1'b0};
                  end
               end
               default: begin
                  // shift the dividend in, zeros after its last bit
                  acc_in = {acc_ff[WIDE_W-2:0], 1'b0};
                  if (root_ff[Q_W-1]) sat_in = 1'b1;
                  if (rem_dv >= den_dv) begin
                     aux_in  = rem_dv - den_dv;
                     root_in = {22'b0, q_cur[Q_W-2:0], 1'b1};
                  end else begin
                     aux_in  = rem_dv;
                     root_in = {22'b0, q_cur[Q_W-2:0], 1'b0};
                  end
               end
            endcase
         end
         U_FIN: begin
            state_in = U_DONE;
            unique case (op_ff)
               OP_MUL:  res_in = acc_ff;
               OP_SQRT: res_in = {64'b0, root_ff};
               default: begin
                  if (dz_ff) res_in = nz_ff ? '0 : WIDE_W'(RATIO_CAP);
                  else if (sat_ff || q_cur > RATIO_CAP) res_in = WIDE_W'(RATIO_CAP);
                  else res_in = WIDE_W'(q_cur);
               end
            endcase
         end
         U_DONE: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= U_IDLE;
      else state_ff <= state_in;
      op_ff   <= op_in;
      acc_ff  <= acc_in;
      aux_ff  <= aux_in;
      bq_ff   <= bq_in;
      root_ff <= root_in;
      res_ff  <= res_in;
      cnt_ff  <= cnt_in;
      sat_ff  <= sat_in;
      dz_ff   <= dz_in;
      nz_ff   <= nz_in;
   end

   assign rsp.done   = (state_ff == U_DONE);
   assign rsp.result = res_ff;

endmodule

// ===== design/vector_distance_unit.sv =====
// Top level of the vector distance unit: channels, registers, final sequencer.
// Depends on vdu_pkg, vdu_if, vdu_accum and vdu_alu.
//
//   port     dir    handshake      word
//   req_ch   in     valid/ready    x_elem, y_elem, last_elem
//   rsp_ch   out    valid/ready    distance
//   csr_*    in     csr_we         csr_index, csr_wdata
//
// Each accepted pair passes the states XY, XX, YY and DD on the shared 17x17 multiplier.
// After the last pair a micro-program of 1 to 15 steps runs on the shared unit, each step
// a multiply, root, divide, add or subtract. Reset clears the sums and loads mode 0,
// epsilon 1. A stalled result holds the sequencer in its final step; no pair is taken
// until the sequencer is idle.
module vector_distance_unit (
   input  logic        clock,
   input  logic        reset,
   vdu_req_if.sink     req_ch,
   vdu_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import vdu_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_ISSUE  = 4'b0010,
      S_WAIT   = 4'b0100,
      S_FINISH = 4'b1000
   } seq_state_type;

   seq_state_type      state_ff, state_in;
   logic [3:0]         step_ff, step_in;
   logic [2:0]         mode_ff;
   logic [15:0]        eps_ff;
   logic [HALF_W-1:0]  rr_ff, cx_ff, cy_ff;
   logic [WIDE_W-1:0]  tmp_ff, den_ff;
   logic [Q_W-1:0]     q_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_data_ff;

   sums_type          sums;
   logic              acc_busy, vec_done, clear, accept, rsp_free;
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;
   uop_type           cur;
   logic [HALF_W-1:0] sxy64, mag_sxy, mag_rr;
   logic              neg;
   logic signed [43:0] val;

   function automatic uop_type mk(input alu_op_type op, input src_type sa,
                                  input src_type sb, input dst_type dst,
                                  input logic last);
      uop_type u;
      u.op   = op;
      u.sa   = sa;
      u.sb   = sb;
      u.dst  = dst;
      u.last = last;
      return u;
   endfunction

   // centred sums: rr = n*Sxy - Sx*Sy, cx = n*Sxx - Sx^2, cy = n*Syy - Sy^2
   function automatic uop_type pre(input logic [3:0] step);
      uop_type u;
      unique case (step)
         4'd0:    u = mk(OP_MUL, SRC_N,   SRC_SXY, DST_TMP, 1'b0);
         4'd1:    u = mk(OP_MUL, SRC_SX,  SRC_SY,  DST_DEN, 1'b0);
         4'd2:    u = mk(OP_SUB, SRC_TMP, SRC_DEN, DST_RR,  1'b0);
         4'd3:    u = mk(OP_MUL, SRC_N,   SRC_SXX, DST_TMP, 1'b0);
         4'd4:    u = mk(OP_MUL, SRC_SX,  SRC_SX,  DST_DEN, 1'b0);
         4'd5:    u = mk(OP_SUB, SRC_TMP, SRC_DEN, DST_CX,  1'b0);
         4'd6:    u = mk(OP_MUL, SRC_N,   SRC_SYY, DST_TMP, 1'b0);
         4'd7:    u = mk(OP_MUL, SRC_SY,  SRC_SY,  DST_DEN, 1'b0);
         default: u = mk(OP_SUB, SRC_TMP, SRC_DEN, DST_CY,  1'b0);
      endcase
      return u;
   endfunction

   function automatic uop_type uop_at(input logic [2:0] mode, input logic [3:0] step);
      uop_type u;
      u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, DST_Q, 1'b1);
      unique case (mode)
         MODE_EUCLID:    u = mk(OP_SQRT, SRC_SDD16, SRC_ZERO, DST_Q, 1'b1);
         MODE_MANHATTAN: u = mk(OP_ADD, SRC_SABD8, SRC_ZERO, DST_Q, 1'b1);
         MODE_MEAN_DOT:  u = mk(OP_DIV0, SRC_MAGSXY, SRC_N, DST_Q, 1'b1);
         MODE_COSINE: begin
            unique case (step)
               4'd0:    u = mk(OP_MUL, SRC_SXX, SRC_SYY, DST_TMP, 1'b0);
               4'd1:    u = mk(OP_SQRT, SRC_TMP, SRC_ZERO, DST_DEN, 1'b0);
               4'd2:    u = mk(OP_ADD, SRC_DEN, SRC_E, DST_DEN, 1'b0);
               default: u = mk(OP_DIV, SRC_MAGSXY, SRC_DEN, DST_Q, 1'b1);
            endcase
         end
         MODE_COVAR: begin
            if (step < 4'd3) u = pre(step);
            else if (step == 4'd3) u = mk(OP_MUL, SRC_N, SRC_NM1, DST_DEN, 1'b0);
            else u = mk(OP_DIV0, SRC_MAGRR, SRC_DEN, DST_Q, 1'b1);
         end
         MODE_SQ_PEARSON: begin
            if (step < 4'd9) u = pre(step);
            else begin
               unique case (step)
                  4'd9:    u = mk(OP_MUL, SRC_N, SRC_N, DST_TMP, 1'b0);
                  4'd10:   u = mk(OP_MUL, SRC_E16, SRC_TMP, DST_DEN, 1'b0);
                  4'd11:   u = mk(OP_MUL, SRC_CX, SRC_CY, DST_TMP, 1'b0);
                  4'd12:   u = mk(OP_ADD, SRC_TMP, SRC_DEN, DST_DEN, 1'b0);
                  4'd13:   u = mk(OP_MUL, SRC_MAGRR, SRC_MAGRR, DST_TMP, 1'b0);
                  default: u = mk(OP_DIV, SRC_TMP, SRC_DEN, DST_Q, 1'b1);
               endcase
            end
         end
         default: begin
            // Pearson and uncentred Pearson share the denominator
            if (step < 4'd9) u = pre(step);
            else begin
               unique case (step)
                  4'd9:  u = mk(OP_MUL, SRC_CX, SRC_CY, DST_TMP, 1'b0);
                  4'd10: u = mk(OP_SQRT, SRC_TMP, SRC_ZERO, DST_DEN, 1'b0);
                  4'd11: u = mk(OP_MUL, SRC_N, SRC_E, DST_TMP, 1'b0);
                  4'd12: u = mk(OP_ADD, SRC_DEN, SRC_TMP, DST_DEN, 1'b0);
                  4'd13: begin
                     if (mode == MODE_PEARSON)
                        u = mk(OP_DIV, SRC_MAGRR, SRC_DEN, DST_Q, 1'b1);
                     else
                        u = mk(OP_MUL, SRC_N, SRC_MAGSXY, DST_TMP, 1'b0);
                  end
                  default: u = mk(OP_DIV, SRC_TMP, SRC_DEN, DST_Q, 1'b1);
               endcase
            end
         end
      endcase
      return u;
   endfunction

   function automatic logic [WIDE_W-1:0] pick(input src_type s);
      logic [WIDE_W-1:0] v;
      unique case (s)
         SRC_N:      v = WIDE_W'(sums.count);
         SRC_NM1:    v = {64'b0, HALF_W'(sums.count) - HALF_W'(1)};
         SRC_SX:     v = {64'b0, HALF_W'(sums.sx)};
         SRC_SY:     v = {64'b0, HALF_W'(sums.sy)};
         SRC_SXY:    v = {64'b0, sxy64};
         SRC_SXX:    v = WIDE_W'(sums.sxx);
         SRC_SYY:    v = WIDE_W'(sums.syy);
         SRC_SDD16:  v = {69'b0, sums.sdd, 16'b0};
         SRC_SABD8:  v = {93'b0, sums.sad, 8'b0};
         SRC_E:      v = WIDE_W'(eps_ff);
         SRC_E16:    v = {96'b0, eps_ff, 16'b0};
         SRC_MAGSXY: v = {64'b0, mag_sxy};
         SRC_MAGRR:  v = {64'b0, mag_rr};
         SRC_CX:     v = {64'b0, cx_ff};
         SRC_CY:     v = {64'b0, cy_ff};
         SRC_TMP:    v = tmp_ff;
         SRC_DEN:    v = den_ff;
         default:    v = '0;
      endcase
      return v;
   endfunction

   assign sxy64   = HALF_W'(sums.sxy);
   assign mag_sxy = sxy64[HALF_W-1] ? -sxy64 : sxy64;
   assign mag_rr  = rr_ff[HALF_W-1] ? -rr_ff : rr_ff;

   assign req_ch.ready = !acc_busy && (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   vdu_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .x_elem    (req_ch.x_elem),
      .y_elem    (req_ch.y_elem),
      .last_elem (req_ch.last_elem),
      .clear     (clear),
      .busy      (acc_busy),
      .vec_done  (vec_done),
      .sums      (sums)
   );

   assign cur           = uop_at(mode_ff, step_ff);
   assign alu_req.start = (state_ff == S_ISSUE);
   assign alu_req.op    = cur.op;
   assign alu_req.a     = pick(cur.sa);
   assign alu_req.b     = pick(cur.sb);

   vdu_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   // sign of the ratio follows its numerator
   always_comb begin
      unique case (mode_ff)
         MODE_COSINE, MODE_UNCENTRED, MODE_MEAN_DOT: neg = sxy64[HALF_W-1];
         MODE_PEARSON, MODE_COVAR:                   neg = rr_ff[HALF_W-1];
         default:                                    neg = 1'b0;
      endcase
      if (mode_ff == MODE_EUCLID || mode_ff == MODE_MANHATTAN)
         val = 44'(q_ff);
      else if (neg)
         val = 44'sd65536 + 44'(q_ff);
      else
         val = 44'sd65536 - 44'(q_ff);
   end

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign clear    = (state_ff == S_FINISH) && rsp_free;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (vec_done) state_in = S_ISSUE;
         end
         S_ISSUE: state_in = S_WAIT;
         S_WAIT: if (alu_rsp.done) begin
            if (cur.last) state_in = S_FINISH;
            else begin
               step_in  = step_ff + 4'd1;
               state_in = S_ISSUE;
            end
         end
         S_FINISH: if (rsp_free) state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         mode_ff      <= MODE_EUCLID;
         eps_ff       <= 16'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_MODE: mode_ff <= csr_wdata[2:0];
               default:  eps_ff  <= csr_wdata;
            endcase
         end
         if (clear) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
      if (state_ff == S_WAIT && alu_rsp.done) begin
         unique case (cur.dst)
            DST_TMP: tmp_ff <= alu_rsp.result;
            DST_DEN: den_ff <= alu_rsp.result;
            DST_RR:  rr_ff  <= alu_rsp.result[HALF_W-1:0];
            DST_CX:  cx_ff  <= alu_rsp.result[HALF_W-1:0];
            DST_CY:  cy_ff  <= alu_rsp.result[HALF_W-1:0];
            default: q_ff   <= alu_rsp.result[Q_W-1:0];
         endcase
      end
      if (clear) begin
         if (val > 44'sd2147483647) rsp_data_ff <= 32'sh7FFFFFFF;
         else if (val < -44'sd2147483648) rsp_data_ff <= 32'sh80000000;
         else rsp_data_ff <= val[31:0];
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.distance = rsp_data_ff;

endmodule

// ===== design/vdu_checker.sv =====
// Port-level checks on the vector distance unit, attached by bind.
// Depends only on the top level's ports.
module vdu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] distance
);

   // a pair keeps the block busy, so pairs are never accepted back to back
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("pair accepted in back-to-back cycles");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(distance))
      else $error("result word changed while stalled");

endmodule

bind vector_distance_unit vdu_checker u_vdu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .distance  (rsp_ch.distance)
);

// ===== dv/tb.sv =====
// Self-checking bench for vector_distance_unit: streams element pairs, predicts each distance.
// Depends on vdu_pkg, vdu_if and the vector_distance_unit design files.
`timescale 1ns / 1ps

module tb;
   import vdu_pkg::*;

   localparam int           CYCLE_LIMIT = 4000000;
   localparam int           DRAIN_WAIT  = 400;
   localparam int           RANDOM_PAIRS = 500;
   localparam logic [159:0] CAP_WIDE = 160'd1 << 40;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   vdu_req_if req_ch ();
   vdu_rsp_if rsp_ch ();

   vector_distance_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Predictor state: configuration copy and exact running sums
   logic [2:0]       pred_mode;
   logic [15:0]      pred_eps;
   longint unsigned  acc_count;
   longint           acc_sx, acc_sy, acc_sxy;
   longint unsigned  acc_sxx, acc_syy, acc_sdd, acc_sad;

   logic signed [31:0] distance_queue[$];
   int  error_count;
   int  pairs_sent;
   int  vectors_sent;
   int  distances_checked;
   int  cycle_count;
   int  burst_left;
   bit  sender_gaps;
   bit  modes_seen[8];

   function automatic logic [63:0] root_floor(input logic [127:0] v);
      logic [63:0]  res;
      logic [63:0]  c;
      logic [127:0] cw;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         c  = res | (64'd1 << b);
         cw = {64'd0, c};
         if (cw * cw <= v) res = c;
      end
      return res;
   endfunction

   // floor(num * 2^16 / den), capped; a zero denominator saturates unless num is zero
   function automatic logic [63:0] capped_ratio(input logic [127:0] num,
                                                input logic [127:0] den);
      logic [159:0] q;
      if (den == '0) return (num == '0) ? 64'd0 : CAP_WIDE[63:0];
      q = {16'd0, num, 16'd0} / {32'd0, den};
      if (q > CAP_WIDE) return CAP_WIDE[63:0];
      return q[63:0];
   endfunction

   function automatic logic [127:0] wide_mul(input longint unsigned a, input longint unsigned b);
      logic [127:0] aw, bw;
      aw = {64'd0, a};
      bw = {64'd0, b};
      return aw * bw;
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic logic signed [31:0] predict_distance();
      longint unsigned n, e, cx, cy, den64;
      longint          r, ratio;
      logic [63:0]     q;
      n     = acc_count;
      e     = pred_eps;
      r     = longint'(n) * acc_sxy - acc_sx * acc_sy;
      cx    = n * acc_sxx - longint'(acc_sx * acc_sx);
      cy    = n * acc_syy - longint'(acc_sy * acc_sy);
      ratio = 0;
      case (pred_mode)
         MODE_EUCLID:    return clamp32(longint'(root_floor({64'd0, acc_sdd} << 16)));
         MODE_MANHATTAN: return clamp32(longint'(acc_sad << 8));
         MODE_COSINE: begin
            den64 = root_floor(wide_mul(acc_sxx, acc_syy)) + e;
            q     = capped_ratio({64'd0, magnitude(acc_sxy)}, {64'd0, den64});
            ratio = (acc_sxy < 0) ? -longint'(q) : longint'(q);
         end
         MODE_PEARSON: begin
            den64 = root_floor(wide_mul(cx, cy)) + n * e;
            q     = capped_ratio({64'd0, magnitude(r)}, {64'd0, den64});
            ratio = (r < 0) ? -longint'(q) : longint'(q);
         end
         MODE_UNCENTRED: begin
            den64 = root_floor(wide_mul(cx, cy)) + n * e;
            q     = capped_ratio({64'd0, n * magnitude(acc_sxy)}, {64'd0, den64});
            ratio = (acc_sxy < 0) ? -longint'(q) : longint'(q);
         end
         MODE_SQ_PEARSON: begin
            q     = capped_ratio(wide_mul(magnitude(r), magnitude(r)),
                                 wide_mul(cx, cy) + wide_mul(e << 16, n * n));
            ratio = longint'(q);
         end
         MODE_MEAN_DOT: if (n != 0) ratio = acc_sxy / longint'(n);
         default:       if (n >= 2) ratio = r / longint'(n * (n - 1));
      endcase
      return clamp32(64'sd65536 - ratio);
   endfunction

   function automatic void clear_sums();
      acc_count = 0;
      acc_sx = 0; acc_sy = 0; acc_sxy = 0;
      acc_sxx = 0; acc_syy = 0; acc_sdd = 0; acc_sad = 0;
   endfunction

   function automatic void absorb_pair(input logic signed [15:0] x, input logic signed [15:0] y,
                                       input logic last);
      longint xv, yv, d;
      xv = x;
      yv = y;
      d  = xv - yv;
      if (acc_count < MAX_LEN) begin
         acc_sx  += xv;
         acc_sy  += yv;
         acc_sxy += xv * yv;
         acc_sxx += xv * xv;
         acc_syy += yv * yv;
         acc_sdd += d * d;
         acc_sad += magnitude(d);
         acc_count++;
      end
      if (last) begin
         distance_queue.push_back(predict_distance());
         modes_seen[pred_mode] = 1'b1;
         vectors_sent++;
         clear_sums();
      end
   endfunction

   // Call at a falling edge; returns at the falling edge after the word is taken
   task automatic send_pair(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic last);
      if (sender_gaps && burst_left == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_ch.valid     = 1'b1;
      req_ch.x_elem    = x;
      req_ch.y_elem    = y;
      req_ch.last_elem = last;
      do @(posedge clock); while (!req_ch.ready);
      absorb_pair(x, y, last);
      pairs_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [15:0] value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      if (index == REG_MODE) pred_mode = value[2:0];
      else pred_eps = value;
   endtask

   // Hold until every distance is back and the sequencer has gone quiet
   task automatic drain();
      req_ch.valid = 1'b0;
      while (distance_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic logic signed [15:0] pick_elem(input int kind);
      case (kind)
         0:       return 16'($urandom());
         1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         2:       return 16'($signed($urandom_range(0, 1024)) - 512);
         default: return 16'($signed($urandom_range(0, 16)) - 8);
      endcase
   endfunction

   task automatic test_directed();
      for (int m = 0; m < 8; m++) begin
         write_reg(REG_MODE, 16'(m));
         write_reg(REG_EPS, (m % 2 == 0) ? 16'd0 : 16'hFFFF);
         send_pair(16'sh7FFF, 16'sh8000, 1'b1);
         send_pair(16'sh8000, 16'sh8000, 1'b0);
         send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
         send_pair(16'sh0000, 16'sh0000, 1'b1);
         send_pair(16'sh0100, 16'sh0200, 1'b0);
         send_pair(-16'sh0100, 16'sh0064, 1'b0);
         send_pair(16'sh0001, -16'sh0001, 1'b1);
         drain();
      end
   endtask

   // Run one vector past the length limit at full-scale values
   task automatic test_overflow();
      write_reg(REG_MODE, 16'($urandom_range(0, 7)));
      write_reg(REG_EPS, 16'd1);
      for (int i = 0; i < MAX_LEN + 6; i++)
         send_pair(16'sh8000, (i % 3 == 0) ? 16'sh8000 : 16'sh7FFF, i == MAX_LEN + 5);
      drain();
   endtask

   task automatic test_random();
      int sent;
      int len;
      int kind;
      logic [15:0] eps;
      sent = 0;
      while (sent < RANDOM_PAIRS) begin
         case ($urandom_range(0, 3))
            0:       eps = 16'd0;
            1:       eps = 16'hFFFF;
            default: eps = 16'($urandom());
         endcase
         write_reg(REG_EPS, eps);
         write_reg(REG_MODE, 16'($urandom_range(0, 7)));
         sender_gaps = $urandom_range(0, 3) != 0;
         repeat ($urandom_range(4, 12)) begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            kind = $urandom_range(0, 4);
            for (int i = 0; i < len; i++) begin
               logic signed [15:0] x, y;
               x = pick_elem(kind);
               y = (kind == 4) ? x : pick_elem(kind);
               send_pair(x, y, i == len - 1);
            end
            sent += len;
         end
         drain();
      end
      sender_gaps = 1'b1;
   endtask

   // Result side: stall in random stretches, sometimes always ready
   int  stall_left;
   int  stall_style;
   always @(negedge clock) begin
      if (cycle_count % 300 == 0) stall_style = $urandom_range(0, 2);
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready = 1'b0;
      end else if (stall_style == 0) begin
         rsp_ch.ready = 1'b1;
      end else if (stall_style == 1) begin
         rsp_ch.ready = 1'($urandom_range(0, 1));
      end else begin
         rsp_ch.ready = 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 40);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("vector_distance_unit: mismatch");
         $finish;
      end else if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (distance_queue.size() == 0) begin
            $error("distance: unexpected word, actual %0d", rsp_ch.distance);
            error_count++;
         end else begin
            logic signed [31:0] want;
            want = distance_queue.pop_front();
            distances_checked++;
            if (rsp_ch.distance !== want) begin
               $error("distance: expected %0d actual %0d", want, rsp_ch.distance);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.x_elem    = '0;
      req_ch.y_elem    = '0;
      req_ch.last_elem = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_we           = 1'b0;
      csr_index        = REG_MODE;
      csr_wdata        = '0;
      cycle_count      = 0;
      stall_left       = 0;
      stall_style      = 0;
      error_count      = 0;
      pairs_sent       = 0;
      vectors_sent     = 0;
      distances_checked = 0;
      burst_left       = 0;
      sender_gaps      = 1'b1;
      pred_mode        = MODE_EUCLID;
      pred_eps         = 16'd1;
      clear_sums();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_overflow();
      test_random();
      drain();

      $display("Sent %0d pairs in %0d vectors; checked %0d distances.",
               pairs_sent, vectors_sent, distances_checked);
      $display("Modes exercised: %0d%0d%0d%0d%0d%0d%0d%0d (mode 0..7), incl. over-length vectors.",
               modes_seen[0], modes_seen[1], modes_seen[2], modes_seen[3],
               modes_seen[4], modes_seen[5], modes_seen[6], modes_seen[7]);
      if (error_count == 0 && distance_queue.size() == 0) begin
         $display("vector_distance_unit: match");
      end else begin
         $display("vector_distance_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== vector_distance_unit.f =====
design/vdu_pkg.sv
design/vdu_if.sv
design/vdu_accum.sv
design/vdu_alu.sv
design/vector_distance_unit.sv
design/vdu_checker.sv
dv/tb.sv
